// ===== src/bcsc_pkg.sv =====
// Package for the battery charge stage controller.
// Holds stage and fault codes, the register map, fixed thresholds and the shared structs.
// No dependencies.
`timescale 1ns / 1ps

package bcsc_pkg;

  localparam int NumCells = 4;

  // charge stage codes
  localparam logic [2:0] ST_CC05    = 3'd0;
  localparam logic [2:0] ST_CC1     = 3'd1;
  localparam logic [2:0] ST_CC2     = 3'd2;
  localparam logic [2:0] ST_CV      = 3'd3;
  localparam logic [2:0] ST_TRICKLE = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;
  localparam logic [2:0] ST_FAULT   = 3'd6;

  // fault reason codes
  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_OV    = 2'd1;
  localparam logic [1:0] FLT_OT    = 2'd2;
  localparam logic [1:0] FLT_UT    = 2'd3;

  // register indexes
  localparam logic [7:0] REG_CELL_OV     = 8'd0;
  localparam logic [7:0] REG_CELL_TRICK  = 8'd1;
  localparam logic [7:0] REG_CELL_NORM   = 8'd2;
  localparam logic [7:0] REG_PACK_OV     = 8'd3;
  localparam logic [7:0] REG_PACK_CV     = 8'd4;
  localparam logic [7:0] REG_TEMP_OVER   = 8'd5;
  localparam logic [7:0] REG_TEMP_UNDER  = 8'd6;
  localparam logic [7:0] REG_TERM_MA     = 8'd7;

  // fixed thresholds and currents
  localparam logic [15:0] PACK_MIN_MV     = 16'd12000;
  localparam logic [15:0] PACK_CC1_MV     = 16'd14000;
  localparam logic [15:0] CELL_CV_ENTRY   = 16'd4150;
  localparam logic [15:0] PACK_RESTART_MV = 16'd16400;
  localparam logic [6:0]  SOC_RESTART     = 7'd95;
  localparam logic [31:0] CC05_LIMIT_S    = 32'd600;
  localparam logic [31:0] CC1_LIMIT_S     = 32'd900;
  localparam logic [31:0] CC2_LIMIT_S     = 32'd600;
  localparam logic [31:0] CV_LIMIT_S      = 32'd1800;
  localparam logic [15:0] SPREAD_MAX_MV   = 16'd300;
  localparam logic [13:0] I_TRICKLE       = 14'd250;
  localparam logic [13:0] I_HALF          = 14'd2500;
  localparam logic [13:0] I_ONE           = 14'd5000;
  localparam logic [13:0] I_TWO           = 14'd10000;
  localparam logic [17:0] TEMP_OVER_HYST  = 18'd50;
  localparam logic [17:0] TEMP_UNDER_HYST = 18'd20;
  // floor(x/10) == (x * DIV10_MUL) >> DIV10_SHIFT for x below 2^18
  localparam logic [15:0] DIV10_MUL       = 16'd52429;
  localparam int          DIV10_SHIFT     = 19;

  typedef struct packed {
    logic [15:0] cell_ov_mv;
    logic [15:0] trickle_floor_mv;
    logic [15:0] cell_normal_mv;
    logic [15:0] pack_ov_mv;
    logic [15:0] cv_start_mv;
    logic [14:0] temp_over_dk;
    logic [14:0] temp_under_dk;
    logic [14:0] term_ma;
  } cfg_t;

  typedef struct packed {
    logic [15:0] mv;
    logic        ov;
  } lane_t;

  typedef struct packed {
    logic [15:0]        pack_mv;
    logic signed [15:0] pack_ma;
    logic [6:0]         charge_percent;
    logic signed [15:0] temp_dk;
    logic               reading_valid;
    logic               motor_stall;
    logic [31:0]        now_seconds;
    logic [15:0]        low_cell_mv;
    logic [15:0]        high_cell_mv;
    logic               cell_ov;
    logic               imbalance;
  } snap_t;

  typedef struct packed {
    logic [2:0]  stage;
    logic [13:0] target_ma;
    logic [1:0]  fault_code;
    logic        imbalance;
  } result_t;

endpackage

// ===== src/bcsc_cell_lane.sv =====
// One cell lane: checks a cell voltage against the overvoltage threshold.
// Depends on bcsc_pkg.
`timescale 1ns / 1ps

module bcsc_cell_lane
  import bcsc_pkg::*;
(
  input  logic [15:0] cell_mv,
  input  logic [15:0] ov_mv,
  output lane_t       lane
);

  assign lane.mv = cell_mv;
  assign lane.ov = (cell_mv >= ov_mv);

endmodule

// ===== src/bcsc_merge.sv =====
// Merges the cell lanes: min/max tree, overvoltage OR and spread check.
// Depends on bcsc_pkg.
`timescale 1ns / 1ps

module bcsc_merge
  import bcsc_pkg::*;
(
  input  lane_t       lanes [NumCells],
  output logic [15:0] low_cell_mv,
  output logic [15:0] high_cell_mv,
  output logic        cell_ov,
  output logic        imbalance
);

  logic [15:0] min01, min23, max01, max23;

  always_comb begin
    min01 = (lanes[1].mv < lanes[0].mv) ? lanes[1].mv : lanes[0].mv;
    min23 = (lanes[3].mv < lanes[2].mv) ? lanes[3].mv : lanes[2].mv;
    max01 = (lanes[1].mv > lanes[0].mv) ? lanes[1].mv : lanes[0].mv;
    max23 = (lanes[3].mv > lanes[2].mv) ? lanes[3].mv : lanes[2].mv;
    low_cell_mv  = (min23 < min01) ? min23 : min01;
    high_cell_mv = (max23 > max01) ? max23 : max01;
    cell_ov  = lanes[0].ov | lanes[1].ov | lanes[2].ov | lanes[3].ov;
    // max >= min always, so the spread never wraps
    imbalance = ((high_cell_mv - low_cell_mv) > SPREAD_MAX_MV);
  end

endmodule

// ===== src/bcsc_stage_fsm.sv =====
// Charge stage machine: fault checks, stage transitions, target current and derates.
// Holds stage, stage start time and fault reason; registers the result word.
// Depends on bcsc_pkg.
`timescale 1ns / 1ps

module bcsc_stage_fsm
  import bcsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  snap_t   snap,
  input  cfg_t    cfg,
  output result_t result
);

  logic [2:0]  stage_r, stage_nxt;
  logic [31:0] start_r, start_nxt;
  logic        started_r;
  logic [1:0]  reason_r, reason_nxt;
  result_t     result_r, result_nxt;

  logic [2:0]         stage_f;
  logic               ov_any, change;
  logic [31:0]        elapsed;
  logic signed [17:0] temp18, over18, under18;
  logic [13:0]        tgt, tgt_derated;
  logic [15:0]        diff;
  logic [19:0]        taper_drop;
  logic [13:0]        taper_tgt;
  logic [16:0]        tgt_x7;
  logic [32:0]        div_prod;

  always_comb begin
    temp18  = $signed({{2{snap.temp_dk[15]}}, snap.temp_dk});
    over18  = $signed({3'b000, cfg.temp_over_dk});
    under18 = $signed({3'b000, cfg.temp_under_dk});
    ov_any  = snap.cell_ov || (snap.pack_mv >= cfg.pack_ov_mv);
    elapsed = started_r ? (snap.now_seconds - start_r) : 32'd0;

    stage_f    = stage_r;
    reason_nxt = reason_r;
    if (ov_any) begin
      stage_f    = ST_FAULT;
      reason_nxt = FLT_OV;
    end
    if (snap.reading_valid && (temp18 >= over18)) begin
      stage_f    = ST_FAULT;
      reason_nxt = FLT_OT;
    end
    if (snap.reading_valid && (temp18 <= under18)) begin
      stage_f    = ST_FAULT;
      reason_nxt = FLT_UT;
    end

    diff       = snap.pack_mv - cfg.cv_start_mv;
    taper_drop = ({4'b0000, diff} << 3) + ({4'b0000, diff} << 1);
    taper_tgt  = 14'(20'd5000 - taper_drop);

    stage_nxt = stage_f;
    change    = 1'b0;
    tgt       = '0;
    unique case (stage_f)
      ST_TRICKLE: begin
        tgt = I_TRICKLE;
        if (snap.low_cell_mv >= cfg.cell_normal_mv && snap.pack_mv >= PACK_MIN_MV &&
            !snap.cell_ov)
          stage_nxt = ST_CC05;
      end
      ST_CC05: begin
        tgt = I_HALF;
        if (elapsed >= CC05_LIMIT_S || snap.pack_mv >= PACK_CC1_MV) stage_nxt = ST_CC1;
        if (snap.low_cell_mv < cfg.trickle_floor_mv) stage_nxt = ST_TRICKLE;
      end
      ST_CC1: begin
        tgt = I_ONE;
        if (snap.high_cell_mv >= CELL_CV_ENTRY || elapsed >= CC1_LIMIT_S) stage_nxt = ST_CV;
        if (snap.low_cell_mv < cfg.trickle_floor_mv) stage_nxt = ST_TRICKLE;
      end
      ST_CC2: begin
        tgt = snap.imbalance ? I_ONE : I_TWO;
        if (snap.high_cell_mv >= CELL_CV_ENTRY || elapsed >= CC2_LIMIT_S) stage_nxt = ST_CV;
      end
      ST_CV: begin
        tgt = I_ONE;
        if (snap.pack_mv > cfg.cv_start_mv) begin
          // taper goes negative past 500 mV over; anything under the floor is zero
          if (taper_drop > 20'd5000 || 15'(taper_tgt) < cfg.term_ma) tgt = '0;
          else tgt = taper_tgt;
        end
        if (snap.pack_ma > 16'sd0 && snap.pack_ma <= $signed({1'b0, cfg.term_ma}))
          stage_nxt = ST_DONE;
        if (elapsed >= CV_LIMIT_S) stage_nxt = ST_DONE;
      end
      ST_DONE: begin
        tgt = '0;
        if (snap.pack_mv <= PACK_RESTART_MV && snap.charge_percent < SOC_RESTART)
          stage_nxt = ST_CC05;
      end
      ST_FAULT: begin
        tgt = '0;
        if (!snap.cell_ov && snap.pack_mv < cfg.pack_ov_mv &&
            temp18 < (over18 - $signed(TEMP_OVER_HYST)) &&
            temp18 > (under18 + $signed(TEMP_UNDER_HYST))) begin
          stage_nxt  = ST_TRICKLE;
          reason_nxt = FLT_NONE;
          change     = 1'b1;
        end
      end
      default: begin
        tgt       = '0;
        stage_nxt = ST_FAULT;
      end
    endcase

    if (stage_nxt != stage_f || change || !started_r) start_nxt = snap.now_seconds;
    else start_nxt = start_r;

    // stall derate: floor(tgt * 7 / 10) via reciprocal multiply
    tgt_x7   = ({3'b000, tgt} << 3) - {3'b000, tgt};
    div_prod = 33'(tgt_x7) * 33'(DIV10_MUL);
    if (snap.motor_stall && tgt != '0) tgt_derated = div_prod[DIV10_SHIFT +: 14];
    else tgt_derated = tgt;
    if (snap.imbalance && tgt_derated > I_ONE) tgt_derated = I_ONE;

    result_nxt.stage      = stage_nxt;
    result_nxt.target_ma  = tgt_derated;
    result_nxt.fault_code = reason_nxt;
    result_nxt.imbalance  = snap.imbalance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= ST_TRICKLE;
      start_r   <= '0;
      started_r <= 1'b0;
      reason_r  <= FLT_NONE;
    end else if (en) begin
      stage_r   <= stage_nxt;
      start_r   <= start_nxt;
      started_r <= 1'b1;
      reason_r  <= reason_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) result_r <= result_nxt;
  end

  assign result = result_r;

endmodule

// ===== src/battery_charge_stage_controller_core.sv =====
// Top level of the four-cell charge stage controller.
// Instantiates bcsc_cell_lane, bcsc_merge and bcsc_stage_fsm; depends on bcsc_pkg.
`timescale 1ns / 1ps

// Takes one pack snapshot per word and returns one result word per snapshot; the snapshot
// is registered on acceptance and the result word in the stage machine. A new word is
// accepted every cycle while the output is not stalled: four cell lanes check the cells in
// parallel and a merge tree forms min, max, overvoltage and spread, registered before the
// stage machine, whose stage, start time and fault reason registers close a feedback loop.
// The pipeline stalls only when the result register is full and out_tready is low.
// Configuration writes are always accepted (cfg_ready is high); indexes above 7 are ignored.

module battery_charge_stage_controller_core
  import bcsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] pack_mv, [31:16] pack_ma, [38:32] charge_percent, [54:39] temp_dk,
  // [70:55] cell0_mv, [86:71] cell1_mv, [102:87] cell2_mv, [118:103] cell3_mv,
  // [119] motor_stall, [151:120] now_seconds
  input  logic [151:0] in_tdata,
  // [0] reading_valid
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] stage, [16:3] target_ma, [18:17] fault_code, [19] imbalance, [23:20] zero
  output logic [23:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  cfg_t    cfg_r;
  lane_t   lanes [NumCells];
  snap_t   snap_in, snap_r;
  logic    s1_valid_r, out_valid_r, out_load;
  result_t result;

  logic [15:0] low_cell_mv, high_cell_mv;
  logic        cell_ov, imbalance;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_ov_mv       <= 16'd4250;
      cfg_r.trickle_floor_mv <= 16'd2900;
      cfg_r.cell_normal_mv   <= 16'd3000;
      cfg_r.pack_ov_mv       <= 16'd17000;
      cfg_r.cv_start_mv      <= 16'd16800;
      cfg_r.temp_over_dk     <= 15'd3180;
      cfg_r.temp_under_dk    <= 15'd2730;
      cfg_r.term_ma          <= 15'd500;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CELL_OV:    cfg_r.cell_ov_mv       <= cfg_data;
        REG_CELL_TRICK: cfg_r.trickle_floor_mv <= cfg_data;
        REG_CELL_NORM:  cfg_r.cell_normal_mv   <= cfg_data;
        REG_PACK_OV:    cfg_r.pack_ov_mv       <= cfg_data;
        REG_PACK_CV:    cfg_r.cv_start_mv      <= cfg_data;
        REG_TEMP_OVER:  cfg_r.temp_over_dk     <= cfg_data[14:0];
        REG_TEMP_UNDER: cfg_r.temp_under_dk    <= cfg_data[14:0];
        REG_TERM_MA:    cfg_r.term_ma          <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // cell lanes and merge
  for (genvar g = 0; g < NumCells; g++) begin : g_lane
    bcsc_cell_lane u_lane (
      .cell_mv (in_tdata[55 + 16*g +: 16]),
      .ov_mv   (cfg_r.cell_ov_mv),
      .lane    (lanes[g])
    );
  end

  bcsc_merge u_merge (
    .lanes        (lanes),
    .low_cell_mv  (low_cell_mv),
    .high_cell_mv (high_cell_mv),
    .cell_ov      (cell_ov),
    .imbalance    (imbalance)
  );

  always_comb begin
    snap_in.pack_mv        = in_tdata[15:0];
    snap_in.pack_ma        = $signed(in_tdata[31:16]);
    snap_in.charge_percent = in_tdata[38:32];
    snap_in.temp_dk        = $signed(in_tdata[54:39]);
    snap_in.reading_valid  = in_tuser[0];
    snap_in.motor_stall    = in_tdata[119];
    snap_in.now_seconds    = in_tdata[151:120];
    snap_in.low_cell_mv    = low_cell_mv;
    snap_in.high_cell_mv   = high_cell_mv;
    snap_in.cell_ov        = cell_ov;
    snap_in.imbalance      = imbalance;
  end

  // two-stage pipeline, advancing whenever the result register can take a word
  assign out_load  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (out_load) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) snap_r <= snap_in;
  end

  bcsc_stage_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (s1_valid_r && out_load),
    .snap   (snap_r),
    .cfg    (cfg_r),
    .result (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, result.imbalance, result.fault_code, result.target_ma,
                       result.stage};

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for battery_charge_stage_controller_core.
// Drives battery snapshots and limit writes, predicts stage, target current, fault and
// imbalance per snapshot, and checks every result word. Depends on bcsc_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import bcsc_pkg::*;

  localparam int          QUIET_LIMIT    = 2000;  // cycles with no handshake at all
  localparam int          SETTLE_CYCLES  = 4;     // wait after the last result word is checked
  localparam int          HOLD_AT        = 250;   // result count that starts the long stall
  localparam int          HOLD_CYCLES    = 300;
  localparam int          ITEMS_PER_PASS = 60;
  localparam int          NUM_PASSES     = 9;
  localparam int          MAX_REPORTS    = 100;
  localparam int          TAPER_MA_PER_MV = 10;
  localparam int          STALL_NUM      = 7;
  localparam int          STALL_DEN      = 10;
  localparam logic [7:0]  REG_UNMAPPED   = 8'hFF;
  localparam logic [1:0]  FLAG_NONE      = 2'b00;
  localparam logic [1:0]  FLAG_VALID     = 2'b01;
  localparam logic [1:0]  FLAG_STALL     = 2'b10;

  typedef struct packed {
    logic [31:0]      now_s;
    logic             stall;
    logic             valid;
    logic [3:0][15:0] cell_mv;
    logic [15:0]      temp_dk;
    logic [6:0]       soc;
    logic [15:0]      pack_ma;
    logic [15:0]      pack_mv;
  } snapshot_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  battery_charge_stage_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // stimulus and expectation stores
  snapshot_t snapshot_queue[$];
  result_t   due_status[$];
  snapshot_t cur_snap;
  int        items_sent = 0;
  int        items_taken = 0;
  int        results_seen = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        idle_max = 6;
  int        in_gap = 0;
  int        ready_wait = 0;
  bit        hold_done = 1'b0;
  bit        in_fire = 1'b0;
  bit        out_fire = 1'b0;
  logic [31:0] sim_now = 32'd5000;

  // tracked copy of the block's limits and state, indexed by register index
  logic [15:0] limits [256];
  logic [2:0]  track_stage;
  logic [31:0] track_start_s;
  logic        track_started;
  logic [1:0]  track_fault;

  function automatic logic [15:0] default_limit(input int idx);
    case (idx[7:0])
      REG_CELL_OV:    return 16'd4250;
      REG_CELL_TRICK: return 16'd2900;
      REG_CELL_NORM:  return 16'd3000;
      REG_PACK_OV:    return 16'd17000;
      REG_PACK_CV:    return 16'd16800;
      REG_TEMP_OVER:  return 16'd3180;
      REG_TEMP_UNDER: return 16'd2730;
      default:        return 16'd500;
    endcase
  endfunction

  // Advances the tracked stage machine by one snapshot and returns the status word it gives.
  function automatic result_t next_charge_result(input snapshot_t s);
    result_t     r;
    logic [15:0] cmin, cmax;
    logic [31:0] elapsed;
    logic [2:0]  nxt;
    logic        ovp, imb, recovered;
    int          tgt, cur, tk, t_over, t_under, pk, cv, term, i;
    cmin = 16'hFFFF;
    cmax = '0;
    ovp = 1'b0;
    recovered = 1'b0;
    tgt = 0;
    cur = $signed(s.pack_ma);
    tk = $signed(s.temp_dk);
    t_over = limits[REG_TEMP_OVER];
    t_under = limits[REG_TEMP_UNDER];
    pk = s.pack_mv;
    cv = limits[REG_PACK_CV];
    term = limits[REG_TERM_MA];
    for (i = 0; i < NumCells; i++) begin
      if (s.cell_mv[i] > cmax) cmax = s.cell_mv[i];
      if (s.cell_mv[i] < cmin) cmin = s.cell_mv[i];
      if (s.cell_mv[i] >= limits[REG_CELL_OV]) ovp = 1'b1;
    end
    imb = (cmax - cmin) > SPREAD_MAX_MV;

    if (!track_started) begin
      track_start_s = s.now_s;
      track_started = 1'b1;
    end
    elapsed = s.now_s - track_start_s;

    // later checks win: under-temperature overrides over-temperature overrides overvoltage
    if (ovp || s.pack_mv >= limits[REG_PACK_OV]) begin
      track_stage = ST_FAULT;
      track_fault = FLT_OV;
    end
    if (s.valid && tk >= t_over) begin
      track_stage = ST_FAULT;
      track_fault = FLT_OT;
    end
    if (s.valid && tk <= t_under) begin
      track_stage = ST_FAULT;
      track_fault = FLT_UT;
    end

    nxt = track_stage;
    case (track_stage)
      ST_TRICKLE: begin
        tgt = I_TRICKLE;
        if (cmin >= limits[REG_CELL_NORM] && s.pack_mv >= PACK_MIN_MV && !ovp) nxt = ST_CC05;
      end
      ST_CC05: begin
        tgt = I_HALF;
        if (elapsed >= CC05_LIMIT_S || s.pack_mv >= PACK_CC1_MV) nxt = ST_CC1;
        if (cmin < limits[REG_CELL_TRICK]) nxt = ST_TRICKLE;
      end
      ST_CC1: begin
        tgt = I_ONE;
        if (cmax >= CELL_CV_ENTRY || elapsed >= CC1_LIMIT_S) nxt = ST_CV;
        if (cmin < limits[REG_CELL_TRICK]) nxt = ST_TRICKLE;
      end
      ST_CC2: begin
        tgt = I_TWO;
        if (cmax >= CELL_CV_ENTRY || elapsed >= CC2_LIMIT_S) nxt = ST_CV;
        if (imb) tgt = I_ONE;
      end
      ST_CV: begin
        tgt = I_ONE;
        if (pk > cv) begin
          tgt = int'(I_ONE) - TAPER_MA_PER_MV * (pk - cv);
          if (tgt < term) tgt = 0;
        end
        if (cur > 0 && cur <= term) nxt = ST_DONE;
        if (elapsed >= CV_LIMIT_S) nxt = ST_DONE;
      end
      ST_DONE: begin
        tgt = 0;
        if (s.pack_mv <= PACK_RESTART_MV && s.soc < SOC_RESTART) nxt = ST_CC05;
      end
      ST_FAULT: begin
        tgt = 0;
        if (!ovp && s.pack_mv < limits[REG_PACK_OV] && tk < t_over - int'(TEMP_OVER_HYST) &&
            tk > t_under + int'(TEMP_UNDER_HYST)) begin
          nxt = ST_TRICKLE;
          track_fault = FLT_NONE;
          recovered = 1'b1;
        end
      end
      default: begin
        tgt = 0;
        nxt = ST_FAULT;
      end
    endcase
    // recovery restarts the timer even though fault is left for trickle anyway
    if (nxt != track_stage || recovered) track_start_s = s.now_s;
    track_stage = nxt;

    if (s.stall && tgt > 0) tgt = (tgt * STALL_NUM) / STALL_DEN;
    if (imb && tgt > int'(I_ONE)) tgt = I_ONE;

    r.stage = track_stage;
    r.target_ma = tgt[13:0];
    r.fault_code = track_fault;
    r.imbalance = imb;
    return r;
  endfunction

  // cells 0..2 at lo, cell 3 at hi
  function automatic snapshot_t snap(input int pk, input int ma, input int soc, input int tk,
                                     input int lo, input int hi, input logic [1:0] flags,
                                     input logic [31:0] now_s);
    snapshot_t s;
    s.pack_mv = pk[15:0];
    s.pack_ma = ma[15:0];
    s.soc = soc[6:0];
    s.temp_dk = tk[15:0];
    s.cell_mv = {hi[15:0], lo[15:0], lo[15:0], lo[15:0]};
    s.valid = flags[0];
    s.stall = flags[1];
    s.now_s = now_s;
    return s;
  endfunction

  // Mostly plausible pack readings on a running clock; about one in ten is pure noise.
  function automatic snapshot_t random_snapshot();
    snapshot_t s;
    int base, sum, i;
    if ($urandom_range(0, 9) == 0) begin
      s.pack_mv = 16'($urandom_range(0, 16'hFFFF));
      s.pack_ma = 16'($urandom_range(0, 16'hFFFF));
      s.soc = 7'($urandom_range(0, 127));
      s.temp_dk = 16'($urandom_range(0, 16'hFFFF));
      for (i = 0; i < NumCells; i++) s.cell_mv[i] = 16'($urandom_range(0, 16'hFFFF));
      s.valid = 1'($urandom_range(0, 1));
      s.stall = 1'($urandom_range(0, 1));
      s.now_s = $urandom;
      return s;
    end
    sim_now += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 250);
    s.now_s = sim_now;
    base = $urandom_range(2850, 4200);
    for (i = 0; i < NumCells; i++) s.cell_mv[i] = 16'(base + $urandom_range(0, 40));
    if ($urandom_range(0, 5) == 0)
      s.cell_mv[2'($urandom_range(0, 3))] = 16'(base + $urandom_range(0, 500));
    if ($urandom_range(0, 15) == 0)
      s.cell_mv[2'($urandom_range(0, 3))] = 16'($urandom_range(4200, 4400));
    sum = 0;
    for (i = 0; i < NumCells; i++) sum += s.cell_mv[i];
    s.pack_mv = 16'(sum + $urandom_range(0, 800) - 300);
    case ($urandom_range(0, 3))
      0:       s.pack_ma = 16'($urandom_range(0, 600));
      1:       s.pack_ma = 16'(0 - $urandom_range(0, 3000));
      default: s.pack_ma = 16'($urandom_range(0, 8000));
    endcase
    s.soc = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 7) == 0) s.temp_dk = 16'($urandom_range(2600, 3300));
    else s.temp_dk = 16'($urandom_range(2760, 3120));
    s.valid = ($urandom_range(0, 9) != 0);
    s.stall = ($urandom_range(0, 3) == 0);
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    if (mismatches < MAX_REPORTS)
      $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
    mismatches++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (items_taken != items_sent || due_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: one snapshot word per handshake, random gap after each
  always @(negedge clk) begin
    if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (snapshot_queue.size() != 0) begin
        cur_snap = snapshot_queue.pop_front();
        in_tdata <= {cur_snap.now_s, cur_snap.stall, cur_snap.cell_mv, cur_snap.temp_dk,
                     cur_snap.soc, cur_snap.pack_ma, cur_snap.pack_mv};
        in_tuser <= cur_snap.valid;
        in_tvalid <= 1'b1;
        in_gap = $urandom_range(0, idle_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall per result word, plus one long hold to back up the pipeline
  always @(negedge clk) begin
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      ready_wait = HOLD_CYCLES;
    end else if (out_fire) begin
      ready_wait = $urandom_range(0, idle_max);
    end
    if (ready_wait > 0) begin
      ready_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: tracks limit writes, predicts on accepted snapshots, checks result words
  always @(posedge clk) begin
    result_t got;
    result_t want;
    int r;
    in_fire = in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (!rst_n) begin
      for (r = 0; r <= REG_TERM_MA; r++) limits[r[7:0]] = default_limit(r);
      track_stage = ST_TRICKLE;
      track_start_s = '0;
      track_started = 1'b0;
      track_fault = FLT_NONE;
    end else if (cfg_valid && cfg_ready && cfg_index <= REG_TERM_MA) begin
      limits[cfg_index] = (cfg_index >= REG_TEMP_OVER) ? {1'b0, cfg_data[14:0]} : cfg_data;
    end
    if (in_fire) begin
      due_status.push_back(next_charge_result(cur_snap));
      items_taken++;
    end
    if (out_fire) begin
      results_seen++;
      got.stage = out_tdata[2:0];
      got.target_ma = out_tdata[16:3];
      got.fault_code = out_tdata[18:17];
      got.imbalance = out_tdata[19];
      if (due_status.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("t=%0t unexpected result word: expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = due_status.pop_front();
        if (got.stage != want.stage) report_mismatch("stage", want.stage, got.stage);
        if (got.target_ma != want.target_ma)
          report_mismatch("target_ma", want.target_ma, got.target_ma);
        if (got.fault_code != want.fault_code)
          report_mismatch("fault_code", want.fault_code, got.fault_code);
        if (got.imbalance != want.imbalance)
          report_mismatch("imbalance", want.imbalance, got.imbalance);
        if (out_tdata[23:20] != '0) report_mismatch("padding", 0, out_tdata[23:20]);
      end
    end
    if (in_fire || out_fire || (rst_n && cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("t=%0t no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_snap(input snapshot_t s);
    snapshot_queue.push_back(s);
    items_sent++;
  endtask

  initial begin
    int ph, r;
    logic [15:0] val;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < NUM_PASSES; ph++) begin
      if (ph > 0) begin
        for (r = 0; r <= REG_TERM_MA; r++) begin
          case (ph)
            2:       val = (r >= REG_TEMP_OVER) ? 16'h8000 : 16'h0000;  // top bit is dropped
            4:       val = 16'hFFFF;
            6:       val = 16'($urandom_range(0, 16'hFFFF));
            default: val = 16'(default_limit(r) + $urandom_range(0, 200) - 100);
          endcase
          write_reg(r[7:0], val);
        end
        write_reg(REG_UNMAPPED, 16'($urandom_range(0, 16'hFFFF)));
      end
      idle_max = (ph % 3 == 1) ? 0 : 6;
      if (ph == 0) begin
        // walk the charge cycle on reset limits, then faults, recovery and odd values
        push_snap(snap(12500, 3000, 20, 2980, 3100, 3100, FLAG_VALID, 32'd1000));
        push_snap(snap(13000, 3000, 30, 2980, 3300, 3350, FLAG_VALID, 32'd1300));
        push_snap(snap(13100, 3000, 35, 2980, 3300, 3350, FLAG_VALID | FLAG_STALL, 32'd1600));
        push_snap(snap(14500, 4000, 50, 2980, 3600, 4150, FLAG_VALID, 32'd1700));
        push_snap(snap(16900, 2000, 80, 2980, 4100, 4140, FLAG_VALID | FLAG_STALL, 32'd1800));
        push_snap(snap(16999, 1500, 90, 2980, 4200, 4240, FLAG_VALID, 32'd1900));
        push_snap(snap(16700, 500, 95, 2980, 4100, 4100, FLAG_VALID, 32'd2000));
        push_snap(snap(16500, 0, 60, 2980, 4000, 4000, FLAG_VALID, 32'd2100));
        push_snap(snap(16400, -200, 94, 2980, 4000, 4000, FLAG_VALID, 32'd2200));
        push_snap(snap(13000, 2500, 50, 2980, 2899, 3000, FLAG_VALID, 32'd2300));
        push_snap(snap(13000, 250, 50, 2980, 3100, 4250, FLAG_VALID, 32'd2400));
        push_snap(snap(17000, 0, 50, 2980, 3100, 3100, FLAG_VALID, 32'd2500));
        push_snap(snap(13000, 0, 50, 2980, 3100, 3100, FLAG_VALID, 32'd2600));
        push_snap(snap(13000, 0, 50, 3180, 3100, 3100, FLAG_VALID, 32'd2700));
        push_snap(snap(13000, 0, 50, 3130, 3100, 3100, FLAG_NONE, 32'd2800));
        push_snap(snap(13000, 0, 50, -5, 3100, 3100, FLAG_VALID, 32'd2900));
        push_snap(snap(13000, 0, 50, 2750, 3100, 3100, FLAG_NONE, 32'd3000));
        push_snap(snap(13000, 0, 50, 2751, 3100, 3100, FLAG_NONE, 32'd3100));
        // elapsed time across the 32-bit wrap
        push_snap(snap(12000, 0, 50, 2980, 3000, 3000, FLAG_VALID, 32'hFFFF_FF00));
        push_snap(snap(12000, 0, 50, 2980, 3000, 3000, FLAG_VALID, 32'h0000_0200));
        push_snap(snap(65535, -1, 127, -1, 65535, 65535, FLAG_VALID | FLAG_STALL,
                       32'hFFFF_FFFF));
        push_snap(snap(0, 0, 0, 0, 0, 0, FLAG_NONE, 32'd0));
      end else begin
        repeat (ITEMS_PER_PASS) push_snap(random_snapshot());
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatches == 0 && due_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
